@@ rtl/first_fit_coalescing_allocator_assert.svh @@
// Assertion macros for the allocator RTL.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFCA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFCA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ffca_pkg.sv @@
package ffca_pkg;

    localparam int OFF_W      = 20;
    localparam int LEN_W      = 21;
    localparam int NEED_W     = 22;
    localparam int MS_W       = 13;
    localparam int RSV_W      = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 21;
    localparam int TDATA_W    = 48;

    localparam int HEAP_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 8;

    localparam logic [LEN_W-1:0] LIMIT_RESET     = 21'h100000;
    localparam logic [LEN_W-1:0] END_RESET       = 21'h10000;
    localparam logic [LEN_W-1:0] GROW_RESET      = 21'h40000;
    localparam logic [MS_W-1:0]  MIN_SPLIT_RESET = 13'd16;
    localparam logic [RSV_W-1:0] RSV_RESET       = 17'd64;
    localparam logic [LEN_W-1:0] USED_MAX        = 21'h1FFFFF;
    localparam logic [MS_W-1:0]  MIN_SPLIT_FLOOR = 13'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_LIMIT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_END = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GROW_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SPLIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESERVED    = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] nxt;
    } hdr_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_A_TEST, ST_A_CHK, ST_A_WS, ST_A_WP, ST_A_WC, ST_A_OK,
        ST_A_MISS, ST_A_GROW2, ST_A_RESTART, ST_F_SIZE, ST_F_WALK, ST_F_STEP,
        ST_F_CHK, ST_F_WRC, ST_F_WRP, ST_F_DONE, ST_NOCHG
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_FORMAT, CMD_LOAD, CMD_A_START, CMD_RD_C, CMD_STEP, CMD_A_FIT,
        CMD_WR_SPLIT, CMD_WR_PREV, CMD_WR_CELL, CMD_A_OK, CMD_GROW_A, CMD_GROW_B,
        CMD_F_START, CMD_F_SIZE, CMD_F_MERGE, CMD_WR_FC, CMD_WR_FP, CMD_F_DONE,
        CMD_NOCHG
    } cmd_t;

    typedef struct packed {
        logic fmt_pend;
        logic op;
        logic cv;
        logic fits;
        logic do_split;
        logic grow_ok;
        logic pre_bad;
        logic size_bad;
        logic walk_more;
        logic overlap_bad;
    } stat_t;

    typedef struct packed {
        logic             valid;
        logic             status;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] used;
    } rslt_t;

endpackage

@@ rtl/first_fit_coalescing_allocator.sv @@
// First-fit heap allocator with an address-ordered, coalescing free list.
// Requests arrive on the s_ stream as one item each: an allocate (opcode 0)
// or a free (opcode 1). Every item yields exactly one result item on the m_
// stream carrying status, the payload offset of a new block and the bytes in
// use. Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata
// while the block is idle; a write of initial_end or reserved_bytes reformats
// the heap in the cycle after, during which s_tready stays low.
// An allocate walks the free cells up to the first fit, and walks them
// again after the heap grows; a free walks the free cells below it. Each
// cell visited costs a read of the header memory (registered read data)
// and a decision step. One item is in work at a time; the next is taken
// once the previous result sits in the output register, even if the
// receiver has not yet taken it.
// After reset the heap is formatted with the reset values.
// When m_tready is low, a finished result waits in the output register and
// the controller holds its last step until the register is free.
`include "first_fit_coalescing_allocator_assert.svh"

module first_fit_coalescing_allocator #(
    parameter int HEAP_BYTES   = ffca_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode [0], alloc_size [21:1], block_offset [41:22], zero fill above.
    input  logic [ffca_pkg::TDATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [0], result_offset [20:1], used_bytes [41:21], zero fill above.
    output logic [ffca_pkg::TDATA_W-1:0]        m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ffca_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ffca_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ffca_pkg::cmd_t  cmd;
    ffca_pkg::stat_t st;
    ffca_pkg::rslt_t rslt;
    logic            in_ready;
    logic            out_free;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          status_reg;
    logic [ffca_pkg::OFF_W-1:0]    offset_reg;
    logic [ffca_pkg::LEN_W-1:0]    used_reg;

    // The output slot can take a result when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = in_ready;

    ffca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    ffca_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_opcode       (s_tdata[0]),
        .in_alloc_size   (s_tdata[21:1]),
        .in_block_offset (s_tdata[41:22]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .st              (st),
        .rslt            (rslt)
    );

    // Output register stage.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (rslt.valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rslt.valid) begin
            status_reg <= rslt.status;
            offset_reg <= rslt.offset;
            used_reg   <= rslt.used;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, used_reg, offset_reg, status_reg};

    // A result is only produced when the output register can hold it.
    `FFCA_ASSERT_SAME(a_rslt_slot, aclk, aresetn, rslt.valid, out_free,
        "result issued while the output register was still full")
    // An accepted item keeps the block busy in the following cycle.
    `FFCA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input taken again right after an accept")
    // Every produced result shows up on the output in the next cycle.
    `FFCA_ASSERT_NEXT(a_rslt_shown, aclk, aresetn, rslt.valid, m_tvalid,
        "produced result did not reach the output")

endmodule

@@ rtl/ffca_ctrl.sv @@
module ffca_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            out_free,
    input  ffca_pkg::stat_t st,
    output ffca_pkg::cmd_t  cmd,
    output logic            in_ready
);

    ffca_pkg::state_t state_reg, state_next;
    logic             pass2_reg, pass2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffca_pkg::ST_IDLE;
            pass2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        cmd        = ffca_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ffca_pkg::ST_IDLE: begin
                if (st.fmt_pend) begin
                    cmd = ffca_pkg::CMD_FORMAT;
                end else begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        cmd        = ffca_pkg::CMD_LOAD;
                        pass2_next = 1'b0;
                        state_next = ffca_pkg::ST_LOAD;
                    end
                end
            end
            ffca_pkg::ST_LOAD: begin
                if (st.op == ffca_pkg::OP_ALLOC) begin
                    cmd        = ffca_pkg::CMD_A_START;
                    state_next = ffca_pkg::ST_A_TEST;
                end else if (st.pre_bad) begin
                    state_next = ffca_pkg::ST_NOCHG;
                end else begin
                    cmd        = ffca_pkg::CMD_F_START;
                    state_next = ffca_pkg::ST_F_SIZE;
                end
            end
            ffca_pkg::ST_A_TEST: begin
                if (st.cv) begin
                    cmd        = ffca_pkg::CMD_RD_C;
                    state_next = ffca_pkg::ST_A_CHK;
                end else if (pass2_reg) begin
                    state_next = ffca_pkg::ST_NOCHG;
                end else begin
                    state_next = ffca_pkg::ST_A_MISS;
                end
            end
            ffca_pkg::ST_A_CHK: begin
                if (st.fits) begin
                    cmd        = ffca_pkg::CMD_A_FIT;
                    state_next = st.do_split ? ffca_pkg::ST_A_WS : ffca_pkg::ST_A_WP;
                end else begin
                    cmd        = ffca_pkg::CMD_STEP;
                    state_next = ffca_pkg::ST_A_TEST;
                end
            end
            ffca_pkg::ST_A_WS: begin
                cmd        = ffca_pkg::CMD_WR_SPLIT;
                state_next = ffca_pkg::ST_A_WP;
            end
            ffca_pkg::ST_A_WP: begin
                cmd        = ffca_pkg::CMD_WR_PREV;
                state_next = ffca_pkg::ST_A_WC;
            end
            ffca_pkg::ST_A_WC: begin
                cmd        = ffca_pkg::CMD_WR_CELL;
                state_next = ffca_pkg::ST_A_OK;
            end
            ffca_pkg::ST_A_OK: begin
                if (out_free) begin
                    cmd        = ffca_pkg::CMD_A_OK;
                    state_next = ffca_pkg::ST_IDLE;
                end
            end
            ffca_pkg::ST_A_MISS: begin
                if (!st.grow_ok) begin
                    state_next = ffca_pkg::ST_NOCHG;
                end else begin
                    cmd        = ffca_pkg::CMD_GROW_A;
                    state_next = ffca_pkg::ST_A_GROW2;
                end
            end
            ffca_pkg::ST_A_GROW2: begin
                cmd        = ffca_pkg::CMD_GROW_B;
                pass2_next = 1'b1;
                state_next = ffca_pkg::ST_A_RESTART;
            end
            ffca_pkg::ST_A_RESTART: begin
                cmd        = ffca_pkg::CMD_A_START;
                state_next = ffca_pkg::ST_A_TEST;
            end
            ffca_pkg::ST_F_SIZE: begin
                cmd        = ffca_pkg::CMD_F_SIZE;
                state_next = st.size_bad ? ffca_pkg::ST_NOCHG : ffca_pkg::ST_F_WALK;
            end
            ffca_pkg::ST_F_WALK: begin
                if (st.walk_more) begin
                    cmd        = ffca_pkg::CMD_RD_C;
                    state_next = ffca_pkg::ST_F_STEP;
                end else begin
                    if (st.cv) begin
                        cmd = ffca_pkg::CMD_RD_C;
                    end
                    state_next = ffca_pkg::ST_F_CHK;
                end
            end
            ffca_pkg::ST_F_STEP: begin
                cmd        = ffca_pkg::CMD_STEP;
                state_next = ffca_pkg::ST_F_WALK;
            end
            ffca_pkg::ST_F_CHK: begin
                if (st.overlap_bad) begin
                    state_next = ffca_pkg::ST_NOCHG;
                end else begin
                    cmd        = ffca_pkg::CMD_F_MERGE;
                    state_next = ffca_pkg::ST_F_WRC;
                end
            end
            ffca_pkg::ST_F_WRC: begin
                cmd        = ffca_pkg::CMD_WR_FC;
                state_next = ffca_pkg::ST_F_WRP;
            end
            ffca_pkg::ST_F_WRP: begin
                cmd        = ffca_pkg::CMD_WR_FP;
                state_next = ffca_pkg::ST_F_DONE;
            end
            ffca_pkg::ST_F_DONE: begin
                if (out_free) begin
                    cmd        = ffca_pkg::CMD_F_DONE;
                    state_next = ffca_pkg::ST_IDLE;
                end
            end
            ffca_pkg::ST_NOCHG: begin
                if (out_free) begin
                    cmd        = ffca_pkg::CMD_NOCHG;
                    state_next = ffca_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ffca_dp.sv @@
module ffca_dp #(
    parameter int HEAP_BYTES   = ffca_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ffca_pkg::cmd_t                      cmd,
    input  logic                                in_opcode,
    input  logic [ffca_pkg::LEN_W-1:0]          in_alloc_size,
    input  logic [ffca_pkg::OFF_W-1:0]          in_block_offset,
    input  logic                                cfg_wr_en,
    input  logic [ffca_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ffca_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output ffca_pkg::stat_t                     st,
    output ffca_pkg::rslt_t                     rslt
);

    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int IW    = $clog2(DEPTH);
    localparam int OW    = ffca_pkg::OFF_W;
    localparam int LW    = ffca_pkg::LEN_W;
    localparam int NW    = ffca_pkg::NEED_W;
    localparam logic [31:0] HB32 = 32'(HEAP_BYTES);
    localparam logic [NW-1:0] HDR_N = NW'(HEADER_BYTES);

    ffca_pkg::hdr_t mem [DEPTH];
    ffca_pkg::hdr_t hdr_q_reg;

    // Configuration registers.
    logic [LW-1:0]              limit_reg, init_end_reg, grow_reg;
    logic [ffca_pkg::MS_W-1:0]  min_split_reg;
    logic [ffca_pkg::RSV_W-1:0] rsv_reg;
    logic                       fmt_pend_reg, fmt_pend_next;

    // Heap state.
    logic [OW-1:0] head_reg, head_next;
    logic          head_v_reg, head_v_next;
    logic [LW-1:0] end_reg, end_next;
    logic [LW-1:0] used_reg, used_next;
    logic [LW-1:0] base_reg, base_next;

    // Per-item working registers.
    logic          op_reg, op_next;
    logic [NW-1:0] need_reg, need_next;
    logic [NW-1:0] g_reg, g_next;
    logic [OW-1:0] boff_reg, boff_next;
    logic [OW-1:0] cur_reg, cur_next;
    logic          cv_reg, cv_next;
    logic          ph_reg, ph_next;
    logic [OW-1:0] p_reg, p_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] take_reg, take_next;
    logic [OW-1:0] nx_reg, nx_next;
    logic [OW-1:0] nx0_reg, nx0_next;
    logic [LW-1:0] split_reg, split_next;
    logic [LW-1:0] size_reg, size_next;
    logic [LW-1:0] nlen_reg, nlen_next;
    logic [OW-1:0] nnext_reg, nnext_next;

    logic           mem_we, mem_re;
    logic [OW-1:0]  mem_waddr, mem_raddr;
    ffca_pkg::hdr_t mem_wdata;

    logic [OW-1:0]  fc;
    logic [NW-1:0]  s4, need_in, g4, rem;
    logic [ffca_pkg::MS_W-1:0] msp;
    logic [31:0]    lim32, r32, e32;
    logic [NW-1:0]  p_end;
    logic           extend;
    logic [NW-1:0]  used_sum;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[IW'(mem_waddr >> 2)] <= mem_wdata;
        end
        if (mem_re) begin
            hdr_q_reg <= mem[IW'(mem_raddr >> 2)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= ffca_pkg::LIMIT_RESET;
            init_end_reg  <= ffca_pkg::END_RESET;
            grow_reg      <= ffca_pkg::GROW_RESET;
            min_split_reg <= ffca_pkg::MIN_SPLIT_RESET;
            rsv_reg       <= ffca_pkg::RSV_RESET;
            fmt_pend_reg  <= 1'b1;
            head_reg      <= '0;
            head_v_reg    <= 1'b0;
            end_reg       <= '0;
            used_reg      <= '0;
            base_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    ffca_pkg::CFG_HEAP_LIMIT:  limit_reg     <= cfg_wdata;
                    ffca_pkg::CFG_INITIAL_END: init_end_reg  <= cfg_wdata;
                    ffca_pkg::CFG_GROW_STEP:   grow_reg      <= cfg_wdata;
                    ffca_pkg::CFG_MIN_SPLIT:   min_split_reg <= cfg_wdata[ffca_pkg::MS_W-1:0];
                    ffca_pkg::CFG_RESERVED:    rsv_reg       <= cfg_wdata[ffca_pkg::RSV_W-1:0];
                    default: begin
                    end
                endcase
            end
            fmt_pend_reg <= fmt_pend_next;
            head_reg     <= head_next;
            head_v_reg   <= head_v_next;
            end_reg      <= end_next;
            used_reg     <= used_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        need_reg  <= need_next;
        g_reg     <= g_next;
        boff_reg  <= boff_next;
        cur_reg   <= cur_next;
        cv_reg    <= cv_next;
        ph_reg    <= ph_next;
        p_reg     <= p_next;
        plen_reg  <= plen_next;
        take_reg  <= take_next;
        nx_reg    <= nx_next;
        nx0_reg   <= nx0_next;
        split_reg <= split_next;
        size_reg  <= size_next;
        nlen_reg  <= nlen_next;
        nnext_reg <= nnext_next;
    end

    // Shared arithmetic.
    assign fc      = boff_reg - OW'(HEADER_BYTES);
    assign s4      = ({1'b0, in_alloc_size} + NW'(3)) & ~NW'(3);
    assign need_in = (s4 + HDR_N + NW'(3)) & ~NW'(3);
    assign g4      = ({1'b0, grow_reg} + NW'(3)) & ~NW'(3);
    assign rem     = {1'b0, hdr_q_reg.len} - need_reg;
    assign msp     = (min_split_reg < ffca_pkg::MIN_SPLIT_FLOOR) ?
                     ffca_pkg::MIN_SPLIT_FLOOR : min_split_reg;
    assign lim32   = (32'(limit_reg) > HB32) ? HB32 : 32'(limit_reg);
    assign r32     = ((32'(rsv_reg) + 32'd3) & ~32'd3) > HB32 ?
                     HB32 : ((32'(rsv_reg) + 32'd3) & ~32'd3);
    assign e32     = (32'(init_end_reg) & ~32'd3) > HB32 ?
                     HB32 : (32'(init_end_reg) & ~32'd3);
    assign p_end   = NW'(p_reg) + NW'(plen_reg);
    assign extend  = !ph_reg && (p_end == NW'(end_reg));
    assign used_sum = NW'(used_reg) + NW'(take_reg);

    // Status toward the controller.
    always_comb begin
        st.fmt_pend    = fmt_pend_reg;
        st.op          = op_reg;
        st.cv          = cv_reg;
        st.fits        = {1'b0, hdr_q_reg.len} >= need_reg;
        st.do_split    = rem >= NW'(msp);
        st.grow_ok     = (32'(end_reg) + 32'(g_reg)) <= lim32;
        st.pre_bad     = (boff_reg < OW'(HEADER_BYTES)) || (fc[1:0] != 2'b00) ||
                         (LW'(fc) < base_reg) || (LW'(fc) >= end_reg);
        st.size_bad    = (hdr_q_reg.len == '0) || (hdr_q_reg.len > (end_reg - LW'(fc)));
        st.walk_more   = cv_reg && (cur_reg < fc);
        st.overlap_bad = (cv_reg && ((cur_reg == fc) ||
                          ((NW'(fc) + NW'(size_reg)) > NW'(cur_reg)))) ||
                         (!ph_reg && (p_end > NW'(fc)));
    end

    always_comb begin
        fmt_pend_next = fmt_pend_reg;
        head_next  = head_reg;
        head_v_next = head_v_reg;
        end_next   = end_reg;
        used_next  = used_reg;
        base_next  = base_reg;
        op_next    = op_reg;
        need_next  = need_reg;
        g_next     = g_reg;
        boff_next  = boff_reg;
        cur_next   = cur_reg;
        cv_next    = cv_reg;
        ph_next    = ph_reg;
        p_next     = p_reg;
        plen_next  = plen_reg;
        take_next  = take_reg;
        nx_next    = nx_reg;
        nx0_next   = nx0_reg;
        split_next = split_reg;
        size_next  = size_reg;
        nlen_next  = nlen_reg;
        nnext_next = nnext_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = cur_reg;
        rslt       = '0;

        unique case (cmd)
            ffca_pkg::CMD_NONE: begin
            end
            ffca_pkg::CMD_FORMAT: begin
                fmt_pend_next = 1'b0;
                base_next  = LW'(r32);
                used_next  = LW'(r32);
                head_next  = OW'(r32);
                if (e32 > r32) begin
                    mem_we      = 1'b1;
                    mem_waddr   = OW'(r32);
                    mem_wdata   = '{len: LW'(e32 - r32), nxt: '0};
                    head_v_next = 1'b1;
                    end_next    = LW'(e32);
                end else begin
                    head_v_next = 1'b0;
                    end_next    = LW'(r32);
                end
            end
            ffca_pkg::CMD_LOAD: begin
                op_next   = in_opcode;
                need_next = need_in;
                boff_next = in_block_offset;
            end
            ffca_pkg::CMD_A_START, ffca_pkg::CMD_F_START: begin
                ph_next  = 1'b1;
                p_next   = '0;
                cur_next = head_reg;
                cv_next  = head_v_reg;
                g_next   = (g4 < need_reg) ? need_reg : g4;
                if (cmd == ffca_pkg::CMD_F_START) begin
                    mem_re    = 1'b1;
                    mem_raddr = fc;
                end
            end
            ffca_pkg::CMD_RD_C: begin
                mem_re = 1'b1;
            end
            ffca_pkg::CMD_STEP: begin
                ph_next   = 1'b0;
                p_next    = cur_reg;
                plen_next = hdr_q_reg.len;
                cur_next  = hdr_q_reg.nxt;
                cv_next   = hdr_q_reg.nxt != '0;
            end
            ffca_pkg::CMD_A_FIT: begin
                nx0_next = hdr_q_reg.nxt;
                if (st.do_split) begin
                    take_next  = LW'(need_reg);
                    nx_next    = cur_reg + OW'(need_reg);
                    split_next = LW'(rem);
                end else begin
                    take_next = hdr_q_reg.len;
                    nx_next   = hdr_q_reg.nxt;
                end
            end
            ffca_pkg::CMD_WR_SPLIT: begin
                mem_we    = 1'b1;
                mem_waddr = nx_reg;
                mem_wdata = '{len: split_reg, nxt: nx0_reg};
            end
            ffca_pkg::CMD_WR_PREV: begin
                if (ph_reg) begin
                    head_next   = nx_reg;
                    head_v_next = nx_reg != '0;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg;
                    mem_wdata = '{len: plen_reg, nxt: nx_reg};
                end
            end
            ffca_pkg::CMD_WR_CELL: begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = '{len: take_reg, nxt: nx0_reg};
            end
            ffca_pkg::CMD_A_OK: begin
                used_next   = (used_sum > NW'(ffca_pkg::USED_MAX)) ?
                              ffca_pkg::USED_MAX : LW'(used_sum);
                rslt.valid  = 1'b1;
                rslt.status = 1'b0;
                rslt.offset = cur_reg + OW'(HEADER_BYTES);
                rslt.used   = used_next;
            end
            ffca_pkg::CMD_GROW_A: begin
                mem_we = 1'b1;
                if (extend) begin
                    mem_waddr = p_reg;
                    mem_wdata = '{len: plen_reg + LW'(g_reg), nxt: '0};
                end else begin
                    mem_waddr = OW'(end_reg);
                    mem_wdata = '{len: LW'(g_reg), nxt: '0};
                    if (ph_reg) begin
                        head_next   = OW'(end_reg);
                        head_v_next = 1'b1;
                    end
                end
            end
            ffca_pkg::CMD_GROW_B: begin
                if (!extend && !ph_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg;
                    mem_wdata = '{len: plen_reg, nxt: OW'(end_reg)};
                end
                end_next = end_reg + LW'(g_reg);
            end
            ffca_pkg::CMD_F_SIZE: begin
                size_next = hdr_q_reg.len;
            end
            ffca_pkg::CMD_F_MERGE: begin
                if (cv_reg && ((NW'(fc) + NW'(size_reg)) == NW'(cur_reg))) begin
                    nlen_next  = size_reg + hdr_q_reg.len;
                    nnext_next = hdr_q_reg.nxt;
                end else if (cv_reg) begin
                    nlen_next  = size_reg;
                    nnext_next = cur_reg;
                end else begin
                    nlen_next  = size_reg;
                    nnext_next = '0;
                end
            end
            ffca_pkg::CMD_WR_FC: begin
                mem_we    = 1'b1;
                mem_waddr = fc;
                mem_wdata = '{len: nlen_reg, nxt: nnext_reg};
            end
            ffca_pkg::CMD_WR_FP: begin
                if (ph_reg) begin
                    head_next   = fc;
                    head_v_next = 1'b1;
                end else if (p_end == NW'(fc)) begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg;
                    mem_wdata = '{len: plen_reg + nlen_reg, nxt: nnext_reg};
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg;
                    mem_wdata = '{len: plen_reg, nxt: fc};
                end
            end
            ffca_pkg::CMD_F_DONE: begin
                used_next   = (used_reg > size_reg) ? (used_reg - size_reg) : '0;
                rslt.valid  = 1'b1;
                rslt.status = 1'b0;
                rslt.offset = '0;
                rslt.used   = used_next;
            end
            ffca_pkg::CMD_NOCHG: begin
                rslt.valid  = 1'b1;
                rslt.status = (op_reg == ffca_pkg::OP_ALLOC);
                rslt.offset = '0;
                rslt.used   = used_reg;
            end
            default: begin
            end
        endcase

        // A new write of the heap end or the reserved size asks for a fresh format.
        if (cfg_wr_en && ((cfg_addr == ffca_pkg::CFG_INITIAL_END) ||
                          (cfg_addr == ffca_pkg::CFG_RESERVED))) begin
            fmt_pend_next = 1'b1;
        end
    end

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Bench-side copies of the geometry. The predictor works in plain 32-bit
    // unsigned arithmetic, so these are kept as ints.
    localparam int unsigned HEAP    = ffca_pkg::HEAP_BYTES_DEF;
    localparam int unsigned HDR     = ffca_pkg::HEADER_BYTES_DEF;
    localparam int unsigned DEPTH   = HEAP / 4;
    localparam int unsigned SAT     = 32'h1FFFFF;
    localparam int unsigned MAX_CYC = 1500000;
    localparam logic        RES_OK    = 1'b0;
    localparam logic        RES_NOMEM = 1'b1;

    typedef struct {
        logic        op;
        int unsigned size;
        int unsigned off;
        bit          from_live;  // take the offset of a live block when the item is driven
        bit          keep_live;  // leave that block listed, so it is freed twice
    } req_t;

    typedef struct {
        logic        status;
        int unsigned offset;
        int unsigned used;
    } resp_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // opcode [0], alloc_size [21:1], block_offset [41:22], zero fill above.
    logic [ffca_pkg::TDATA_W-1:0]     s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // status [0], result_offset [20:1], used_bytes [41:21], zero fill above.
    logic [ffca_pkg::TDATA_W-1:0]     m_tdata;
    logic                             cfg_wr_en = 1'b0;
    logic [ffca_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [ffca_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    first_fit_coalescing_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heap predictor. Its own copy of the registers, the list head, the heap
    // end, the used count and a sparse map of the cell headers. Only header
    // words that were written are present in the map.
    // ------------------------------------------------------------------
    int unsigned lim_reg, end_reg, step_reg, split_reg, rsv_reg;
    int unsigned head_off, heap_top, used_cnt, base_cell;
    bit          head_ok;
    int unsigned cell_len [int unsigned];
    int unsigned cell_nxt [int unsigned];

    function automatic int unsigned widx(int unsigned off);
        return (off >> 2) % DEPTH;
    endfunction

    function automatic bit hdr_known(int unsigned off);
        return cell_len.exists(widx(off));
    endfunction

    function automatic int unsigned len_of(int unsigned off);
        return cell_len.exists(widx(off)) ? cell_len[widx(off)] : 0;
    endfunction

    function automatic int unsigned nxt_of(int unsigned off);
        return cell_nxt.exists(widx(off)) ? cell_nxt[widx(off)] : 0;
    endfunction

    function automatic void set_len(int unsigned off, int unsigned v);
        if (!cell_nxt.exists(widx(off))) cell_nxt[widx(off)] = 0;
        cell_len[widx(off)] = v;
    endfunction

    function automatic void set_nxt(int unsigned off, int unsigned v);
        if (!cell_len.exists(widx(off))) cell_len[widx(off)] = 0;
        cell_nxt[widx(off)] = v;
    endfunction

    // Lay the heap out again: one free cell from the aligned base to the
    // aligned end, or an empty list when there is no room between them.
    function automatic void format_heap();
        int unsigned r, e;
        r = (rsv_reg + 3) & ~32'd3;
        e = end_reg & ~32'd3;
        if (r > HEAP) r = HEAP;
        if (e > HEAP) e = HEAP;
        base_cell = r;
        used_cnt  = r;
        head_off  = r;
        if (e > r) begin
            set_len(r, e - r);
            set_nxt(r, 0);
            head_ok  = 1'b1;
            heap_top = e;
        end else begin
            head_ok  = 1'b0;
            heap_top = r;
        end
    endfunction

    // Walks the free list for the first cell of at least need bytes. Returns
    // the bytes taken, or zero on a miss, in which case the last cell seen is
    // reported so that growth can extend or link after it.
    function automatic int unsigned take_first_fit(int unsigned need, output int unsigned got,
                                                   output bit at_head, output int unsigned tail);
        int unsigned msp, prv, cur, n, ln, nx0, nx;
        bit          ph, cv;
        msp = split_reg < 4 ? 4 : split_reg;
        ph = 1'b1;
        prv = 0;
        cur = head_off;
        cv = head_ok;
        got = 0;
        for (n = 0; cv && n < DEPTH; n++) begin
            ln = len_of(cur);
            nx0 = nxt_of(cur);
            if (ln >= need) begin
                if (ln - need < msp) begin
                    need = ln;
                    nx = nx0;
                end else begin
                    nx = cur + need;
                    set_len(nx, ln - need);
                    set_nxt(nx, nx0);
                end
                if (ph) begin
                    head_off = nx;
                    head_ok = (nx != 0);
                end else begin
                    set_nxt(prv, nx);
                end
                set_len(cur, need);
                got = cur;
                at_head = 1'b0;
                tail = 0;
                return need;
            end
            ph = 1'b0;
            prv = cur;
            cur = nx0;
            cv = (cur != 0);
        end
        at_head = ph;
        tail = prv;
        return 0;
    endfunction

    function automatic resp_t predict_alloc(int unsigned size);
        resp_t       r;
        int unsigned need, got, tail, taken, g, lim;
        bit          lh;
        need = (((size + 3) & ~32'd3) + HDR + 3) & ~32'd3;
        r.status = RES_NOMEM;
        r.offset = 0;
        taken = take_first_fit(need, got, lh, tail);
        if (taken == 0) begin
            g = (step_reg + 3) & ~32'd3;
            lim = lim_reg > HEAP ? HEAP : lim_reg;
            if (g < need) g = need;
            // A refused growth leaves everything as it was.
            if (heap_top + g > lim) begin
                r.used = used_cnt;
                return r;
            end
            if (!lh && tail + len_of(tail) == heap_top) begin
                set_len(tail, len_of(tail) + g);
            end else begin
                set_len(heap_top, g);
                set_nxt(heap_top, 0);
                if (lh) begin
                    head_off = heap_top;
                    head_ok = 1'b1;
                end else begin
                    set_nxt(tail, heap_top);
                end
            end
            heap_top += g;
            taken = take_first_fit(need, got, lh, tail);
            if (taken == 0) begin
                r.used = used_cnt;
                return r;
            end
        end
        used_cnt = (taken > SAT - used_cnt) ? SAT : used_cnt + taken;
        r.status = RES_OK;
        r.offset = (got + HDR) & 32'hFFFFF;
        r.used = used_cnt;
        return r;
    endfunction

    // Returns the cell back to the list in address order and merges it with
    // its neighbors. Any malformed or overlapping request is silently ignored.
    function automatic void predict_free(int unsigned boff);
        int unsigned c, sz, prv, t, n, tl, tn, cl, cn;
        bit          ph, tv;
        if (boff < HDR) return;
        c = boff - HDR;
        if ((c & 3) != 0 || c < base_cell || c >= heap_top) return;
        sz = len_of(c);
        if (sz == 0 || sz > heap_top - c) return;
        ph = 1'b1;
        prv = 0;
        t = head_off;
        tv = head_ok;
        for (n = 0; tv && t < c && n < DEPTH; n++) begin
            ph = 1'b0;
            prv = t;
            t = nxt_of(t);
            tv = (t != 0);
        end
        if (tv && (t == c || c + sz > t)) return;
        if (!ph && prv + len_of(prv) > c) return;
        if (tv) begin
            if (c + sz == t) begin
                tl = len_of(t);
                tn = nxt_of(t);
                set_len(c, sz + tl);
                set_nxt(c, tn);
            end else begin
                set_nxt(c, t);
            end
        end else begin
            set_nxt(c, 0);
        end
        if (ph) begin
            // The head itself is never merged into as a lower neighbor.
            head_off = c;
            head_ok = 1'b1;
        end else if (prv + len_of(prv) == c) begin
            cl = len_of(c);
            cn = nxt_of(c);
            set_len(prv, len_of(prv) + cl);
            set_nxt(prv, cn);
        end else begin
            set_nxt(prv, c);
        end
        used_cnt = used_cnt > sz ? used_cnt - sz : 0;
    endfunction

    function automatic resp_t predict_request(req_t q);
        resp_t r;
        if (q.op == ffca_pkg::OP_ALLOC) begin
            r = predict_alloc(q.size);
        end else begin
            predict_free(q.off);
            r.status = RES_OK;
            r.offset = 0;
            r.used = used_cnt;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------
    req_t        pending_reqs[$];
    resp_t       expected_resps[$];
    int unsigned live_blocks[$];   // payload offsets of blocks believed allocated
    int unsigned n_alloc_ok, n_alloc_fail, n_free, n_errors, cycle_cnt;
    bit          hold_request;
    req_t        cur_req;
    int          burst_left, gap_left;

    // Resolves the offset of a free request against the predictor state at
    // the moment the item goes on the bus. A free whose header word was
    // never written would read an undefined header, so such an offset is
    // swapped for a live block or for an offset that fails the early checks.
    function automatic req_t resolve_req(req_t q);
        int unsigned c, k;
        if (q.op == ffca_pkg::OP_FREE) begin
            if (q.from_live && live_blocks.size() > 0) begin
                k = $urandom_range(live_blocks.size() - 1);
                q.off = live_blocks[k];
                if (!q.keep_live) live_blocks.delete(k);
            end
            c = q.off - HDR;
            if (q.off >= HDR && (c & 3) == 0 && c >= base_cell && c < heap_top &&
                !hdr_known(c)) begin
                q.off = live_blocks.size() > 0 ? live_blocks[0] : 0;
            end
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of items separated by random gaps. The predictor runs
    // on each accepted item before the next one is resolved, so the next
    // free request sees the state that the block will see.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit                           acc, nv;
        resp_t                        r;
        logic [ffca_pkg::TDATA_W-1:0] d;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            acc = s_tvalid && s_tready;
            nv = s_tvalid && !acc;
            if (acc) begin
                r = predict_request(cur_req);
                expected_resps.push_back(r);
                if (cur_req.op == ffca_pkg::OP_FREE) n_free++;
                else if (r.status == RES_OK) begin
                    n_alloc_ok++;
                    live_blocks.push_back(r.offset);
                end else n_alloc_fail++;
            end
            if (!s_tvalid || acc) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = resolve_req(pending_reqs.pop_front());
                    d = '0;
                    d[0] = cur_req.op;
                    d[21:1] = cur_req.size[20:0];
                    d[41:22] = cur_req.off[19:0];
                    s_tdata <= d;
                    nv = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(12, 1);
                        // Roughly a third of the bursts run back to back.
                        gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            s_tvalid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, redrawn after random run lengths, and
    // one long hold-off on request so that a result parks in the output
    // register and the block stops taking items.
    // ------------------------------------------------------------------
    int unsigned rx_mode, rx_left, hold_left;
    bit          hold_seen;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_mode <= 0;
            rx_left <= 0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_request && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(2);
                rx_left <= $urandom_range(200, 20);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(1) == 1);
                default: m_tready <= ($urandom_range(4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result is matched against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result item, tdata %h", $realtime, m_tdata);
                n_errors++;
            end else begin
                e = expected_resps.pop_front();
                if (m_tdata[0] !== e.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, e.status, m_tdata[0]);
                    n_errors++;
                end
                if (m_tdata[20:1] !== e.offset[19:0]) begin
                    $display("%0t: result_offset expected %0d actual %0d",
                             $realtime, e.offset, m_tdata[20:1]);
                    n_errors++;
                end
                if (m_tdata[41:21] !== e.used[20:0]) begin
                    $display("%0t: used_bytes expected %0d actual %0d",
                             $realtime, e.used, m_tdata[41:21]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYC) begin
            $display("first_fit_coalescing_allocator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void push_alloc(int unsigned size);
        req_t q;
        q.op = ffca_pkg::OP_ALLOC;
        q.size = size;
        q.off = $urandom_range(32'hFFFFF);
        q.from_live = 1'b0;
        q.keep_live = 1'b0;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_free(int unsigned off, bit from_live, bit keep);
        req_t q;
        q.op = ffca_pkg::OP_FREE;
        q.size = $urandom_range(32'h1FFFFF);
        q.off = off;
        q.from_live = from_live;
        q.keep_live = keep;
        pending_reqs.push_back(q);
    endfunction

    // Mostly small requests, now and then mid-sized, rarely anything up to
    // the heap size; frees mostly return live blocks.
    function automatic void push_random(int unsigned free_pct);
        int unsigned p;
        if ($urandom_range(99) < free_pct) begin
            p = $urandom_range(99);
            if (p < 85) push_free(0, 1'b1, 1'b0);
            else if (p < 92) push_free(0, 1'b1, 1'b1);
            else push_free($urandom_range(32'hFFFFF), 1'b0, 1'b0);
        end else begin
            p = $urandom_range(99);
            if (p < 75) push_alloc($urandom_range(512));
            else if (p < 95) push_alloc($urandom_range(16384));
            else push_alloc($urandom_range(HEAP));
        end
    endfunction

    // The state is sampled on the falling edge, after the driver's updates
    // of the rising edge have settled.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
            @(negedge aclk);
        // Every item yields a result, so the block is idle by now; a short
        // pause covers the step that hands the result over.
        repeat (10) @(posedge aclk);
    endtask

    // Writes one register and mirrors it into the predictor. A write of the
    // heap end or of the reserved size lays the heap out again.
    task automatic write_reg(logic [ffca_pkg::CFG_ADDR_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[ffca_pkg::CFG_DATA_W-1:0];
        case (idx)
            ffca_pkg::CFG_HEAP_LIMIT:  lim_reg = val & 32'h1FFFFF;
            ffca_pkg::CFG_INITIAL_END: begin
                end_reg = val & 32'h1FFFFF;
                format_heap();
                live_blocks.delete();
            end
            ffca_pkg::CFG_GROW_STEP:   step_reg = val & 32'h1FFFFF;
            ffca_pkg::CFG_MIN_SPLIT:   split_reg = val & 32'h1FFF;
            ffca_pkg::CFG_RESERVED:    begin
                rsv_reg = val & 32'h1FFFF;
                format_heap();
                live_blocks.delete();
            end
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(int unsigned lim, int unsigned step, int unsigned split,
                             int unsigned rsv, int unsigned top);
        wait_idle();
        write_reg(ffca_pkg::CFG_HEAP_LIMIT, lim);
        write_reg(ffca_pkg::CFG_GROW_STEP, step);
        write_reg(ffca_pkg::CFG_MIN_SPLIT, split);
        write_reg(ffca_pkg::CFG_RESERVED, rsv);
        write_reg(ffca_pkg::CFG_INITIAL_END, top);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        int i;
        lim_reg = ffca_pkg::LIMIT_RESET;
        end_reg = ffca_pkg::END_RESET;
        step_reg = ffca_pkg::GROW_RESET;
        split_reg = ffca_pkg::MIN_SPLIT_RESET;
        rsv_reg = ffca_pkg::RSV_RESET;
        format_heap();
        n_alloc_ok = 0;
        n_alloc_fail = 0;
        n_free = 0;
        n_errors = 0;
        cycle_cnt = 0;
        hold_request = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Directed part under the reset settings: zero and heap-sized requests,
        // splits, growth of a cell that touches the end, refused growth, and
        // malformed frees.
        push_alloc(0);
        push_alloc(1);
        push_alloc(100);
        push_alloc(HEAP);                 // far past the limit, refused
        push_alloc(65536 - 64 - 8 - 24);  // misses, so the cell at the end grows
        push_alloc(200000);               // fits in the grown cell, split
        push_free(0, 1'b0, 1'b0);         // below the header size
        push_free(7, 1'b0, 1'b0);
        push_free(73, 1'b0, 1'b0);        // cell offset not word aligned
        push_free(32'hFFFFF, 1'b0, 1'b0); // all offset bits set, past the end
        push_free(8, 1'b0, 1'b0);         // below the reserved base
        push_free(72, 1'b0, 1'b0);        // first block, becomes the head
        push_free(72, 1'b0, 1'b0);        // same block again
        push_free(84, 1'b0, 1'b0);        // inside the second block, swapped for a live one
        push_free(0, 1'b1, 1'b0);
        push_free(0, 1'b1, 1'b0);
        push_alloc(24);
        push_free(0, 1'b1, 1'b0);
        for (i = 0; i < 100; i++) push_random(40);

        // Low ends but for the limit: no reserved area and an empty list, so
        // the first growth builds the head; the limit register above the
        // heap size acts as the heap size.
        configure(32'h1FFFFF, 4, 4, 0, 0);
        push_alloc(0);
        push_alloc(3);
        push_free(0, 1'b1, 1'b0);
        for (i = 0; i < 100; i++) push_random(45);

        // No growth allowed and a base above the end: every allocate fails.
        configure(0, 4, 16, 65536, 4096);
        for (i = 0; i < 30; i++) push_random(30);

        // Top ends: whole heap and growth step, split of 4096, odd reserved size.
        // The long receiver hold-off happens here.
        configure(HEAP, HEAP, 4096, 3, HEAP);
        for (i = 0; i < 100; i++) push_random(40);
        hold_request = 1'b1;

        // Middle settings with unaligned values and frequent growth.
        configure(300000, 1000, 13, 64, 8191);
        for (i = 0; i < 120; i++) push_random(40);

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("Covered %0d allocations (%0d refused) and %0d frees over five settings,",
                 n_alloc_ok + n_alloc_fail, n_alloc_fail, n_free);
        $display("including empty-list growth, refused growth and malformed frees.");
        if (n_errors == 0 && expected_resps.size() == 0) begin
            $display("first_fit_coalescing_allocator: match");
        end else begin
            $display("first_fit_coalescing_allocator: mismatch");
        end
        $finish;
    end

endmodule
